>>> rtl/rlff_pkg.sv
// ----------------------------------------------------------------------------
// rlff_pkg
// Shared constants, types and helpers of the row FIR filter with per-tap
// product tables.
// ----------------------------------------------------------------------------
`default_nettype none

package rlff_pkg;

  // Pixel and table geometry
  localparam int PIX_W       = 8;
  localparam int LEVELS      = 256;
  localparam int LEVEL_W     = $clog2(LEVELS);
  localparam int WORD_W      = 24;
  localparam int TAP_FIELD_W = 5;
  localparam int MAX_TAPS    = 19;

  // Window and counters
  localparam int WIN_W = $clog2(MAX_TAPS);
  localparam int CNT_W = $clog2(MAX_TAPS + 1);
  localparam int RAD_W = $clog2((MAX_TAPS - 1) / 2 + 1);

  // Configuration registers
  localparam int TAP_COUNT_W = 5;
  localparam int OFF_W       = 25;
  localparam int SHIFT_W     = 5;
  localparam int CFG_DATA_W  = 25;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_TAP_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUND_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_AMOUNT = 2'd2;

  localparam logic [TAP_COUNT_W-1:0] TAP_COUNT_RESET = 5'd7;

  // Item kinds carried on s_tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  // Stream widths
  localparam int S_FIELDS_W = PIX_W + TAP_FIELD_W + LEVEL_W + WORD_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = 8;

  // Positions of the input fields inside s_tdata
  localparam int TAP_LSB   = PIX_W;
  localparam int LEVEL_LSB = TAP_LSB + TAP_FIELD_W;
  localparam int WORD_LSB  = LEVEL_LSB + LEVEL_W;

  // Adder tree: one term per tap plus the doubled offset
  localparam int SUM_W    = WORD_W + $clog2(MAX_TAPS + 4);
  localparam int N_TERMS  = MAX_TAPS + 1;
  localparam int GRP      = 4;
  localparam int N_GROUPS = (N_TERMS + GRP - 1) / GRP;

  // Output queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0]           pixel_t;
  typedef pixel_t [MAX_TAPS-1:0]      window_t;
  typedef logic [LEVEL_W-1:0]         level_t;
  typedef logic [WORD_W-1:0]          word_t;
  typedef logic [TAP_FIELD_W-1:0]     tap_idx_t;
  typedef logic [CNT_W-1:0]           cnt_t;
  typedef logic [RAD_W-1:0]           rad_t;
  typedef logic signed [SUM_W-1:0]    sum_t;

  typedef struct packed {
    logic [TAP_COUNT_W-1:0] tap_count;
    logic signed [OFF_W-1:0] round_offset;
    logic [SHIFT_W-1:0]     shift_amount;
  } cfg_t;

  typedef struct packed {
    logic     we;
    tap_idx_t tap;
    level_t   level;
    word_t    word;
  } tbl_wr_t;

  typedef struct packed {
    logic valid;
    logic row_last;
    logic run_last;
  } step_t;

  typedef struct packed {
    pixel_t pixel;
    logic   row_last;
    logic   run_last;
  } res_t;

  // Kernel length actually used: limited to MAX_TAPS, even values lowered
  // by one, zero treated as one.
  function automatic cnt_t eff_taps(input logic [TAP_COUNT_W-1:0] tc);
    cnt_t n;
    if (tc > MAX_TAPS) begin
      n = CNT_W'(MAX_TAPS);
    end else begin
      n = CNT_W'(tc);
    end
    if (!n[0]) begin
      n = (n == '0) ? CNT_W'(1) : n - CNT_W'(1);
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rlff_tap_bank.sv
// ----------------------------------------------------------------------------
// rlff_tap_bank
// Product table of one tap: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module rlff_tap_bank
  import rlff_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   we,
  input  wire level_t waddr,
  input  wire word_t  wdata,
  input  wire level_t raddr,
  output word_t       rdata
);

  word_t mem [LEVELS];

  // A read and a write to the same word in one cycle return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/rlff_window_ctrl.sv
// ----------------------------------------------------------------------------
// rlff_window_ctrl
// Input side: takes pixel and table load transactions, keeps the pixel
// window and row fill count, and replays the last pixel at a row end.
// ----------------------------------------------------------------------------
`default_nettype none

module rlff_window_ctrl
  import rlff_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  input  wire logic                   s_tlast,
  input  wire logic                   s_tuser,
  input  wire logic [TAP_COUNT_W-1:0] tap_count,
  input  wire logic                   credit_ok,
  output window_t                     window,
  output step_t                       step_out,
  output logic                        produce,
  output tbl_wr_t                     tbl_wr
);

  cnt_t    fill_count;
  rad_t    flush_left;
  pixel_t  flush_pix;

  cnt_t    n;
  rad_t    r;
  pixel_t  pix_in;
  pixel_t  step_pix;
  logic    flushing;
  logic    in_acc;
  logic    pix_step;
  logic    flush_step;
  logic    step;
  logic    row_start;
  logic    last_step;
  logic    row_done;
  cnt_t    cnt_after;
  window_t window_next;

  always_comb begin
    n          = eff_taps(tap_count);
    r          = RAD_W'((n - CNT_W'(1)) >> 1);
    pix_in     = s_tdata[PIX_W-1:0];
    flushing   = (flush_left != '0);
    s_tready   = !flushing && credit_ok;
    in_acc     = s_tvalid && s_tready;
    pix_step   = in_acc && (s_tuser == REQ_PIXEL);
    flush_step = flushing && credit_ok;
    step       = pix_step || flush_step;
    step_pix   = flushing ? flush_pix : pix_in;
    row_start  = pix_step && (fill_count == '0);

    // The first pixel of a row fills the whole window.
    if (row_start) begin
      for (int i = 0; i < MAX_TAPS; i++) begin
        window_next[i] = step_pix;
      end
      cnt_after = CNT_W'(r) + CNT_W'(1);
    end else begin
      for (int i = 0; i < MAX_TAPS - 1; i++) begin
        window_next[i] = window[i + 1];
      end
      window_next[MAX_TAPS-1] = step_pix;
      cnt_after = (fill_count >= CNT_W'(MAX_TAPS)) ? fill_count : fill_count + CNT_W'(1);
    end

    if (flush_step) begin
      last_step = (flush_left == RAD_W'(1));
      row_done  = last_step;
    end else begin
      last_step = !s_tlast || (r == '0);
      row_done  = s_tlast && (r == '0);
    end

    produce = step && (cnt_after >= n);

    tbl_wr.we    = in_acc && (s_tuser == REQ_LOAD) &&
                   (s_tdata[LEVEL_LSB-1:TAP_LSB] < MAX_TAPS);
    tbl_wr.tap   = s_tdata[LEVEL_LSB-1:TAP_LSB];
    tbl_wr.level = s_tdata[WORD_LSB-1:LEVEL_LSB];
    tbl_wr.word  = s_tdata[WORD_LSB+WORD_W-1:WORD_LSB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      fill_count     <= '0;
      flush_left     <= '0;
      step_out.valid <= 1'b0;
    end else begin
      step_out.valid <= produce;
      if (step) begin
        window     <= window_next;
        fill_count <= row_done ? '0 : cnt_after;
      end
      if (pix_step && s_tlast) begin
        flush_left <= r;
      end else if (flush_step) begin
        flush_left <= flush_left - RAD_W'(1);
      end
    end
    if (pix_step) begin
      flush_pix <= pix_in;
    end
    step_out.row_last <= row_done;
    step_out.run_last <= last_step;
  end

  a_flush_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (flush_left != '0) |-> !s_tready)
    else $error("input taken while a row end is still being replayed");

  a_fill_bounded: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(MAX_TAPS))
    else $error("row fill count beyond window depth");

  a_flush_loaded: assert property (@(posedge clk) disable iff (rst)
    (pix_step && s_tlast && (r != '0)) |=> (flush_left == $past(r)))
    else $error("row end did not start the replay of its last pixel");

endmodule

`default_nettype wire

>>> rtl/rlff_datapath.sv
// ----------------------------------------------------------------------------
// rlff_datapath
// Table lookup per tap, registered adder tree, arithmetic shift and
// truncation to the output pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rlff_datapath
  import rlff_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire cfg_t    cfg,
  input  wire window_t window,
  input  wire step_t   step_in,
  input  wire tbl_wr_t tbl_wr,
  output logic         res_valid,
  output res_t         res
);

  cnt_t   n;
  level_t raddr [MAX_TAPS];
  word_t  rdata [MAX_TAPS];
  sum_t   term  [N_TERMS];
  sum_t   grp_sum [N_GROUPS];
  sum_t   grp_q   [N_GROUPS];
  sum_t   total;
  sum_t   total_q;
  sum_t   shifted;
  step_t  p2;
  step_t  p3;
  step_t  p4;

  assign n = eff_taps(cfg.tap_count);

  // Tap k looks at the k-th oldest of the newest n window pixels.
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_tap
    logic [CNT_W:0] pos;
    assign pos = (CNT_W + 1)'(MAX_TAPS + k) - {1'b0, n};
    assign raddr[k] = (k < n) ? window[pos[WIN_W-1:0]] : '0;

    rlff_tap_bank u_bank (
      .clk   (clk),
      .we    (tbl_wr.we && (tbl_wr.tap == TAP_FIELD_W'(k))),
      .waddr (tbl_wr.level),
      .wdata (tbl_wr.word),
      .raddr (raddr[k]),
      .rdata (rdata[k])
    );
  end

  always_comb begin
    for (int k = 0; k < MAX_TAPS; k++) begin
      term[k] = (k < n) ? {{(SUM_W - WORD_W){rdata[k][WORD_W-1]}}, rdata[k]} : '0;
    end
    // The offset enters the sum twice.
    term[MAX_TAPS] = {{(SUM_W - OFF_W - 1){cfg.round_offset[OFF_W-1]}},
                      cfg.round_offset, 1'b0};
  end

  always_comb begin
    for (int g = 0; g < N_GROUPS; g++) begin
      grp_sum[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        if (g * GRP + j < N_TERMS) begin
          grp_sum[g] = grp_sum[g] + term[g * GRP + j];
        end
      end
    end
  end

  always_comb begin
    total = '0;
    for (int g = 0; g < N_GROUPS; g++) begin
      total = total + grp_q[g];
    end
  end

  assign shifted = total_q >>> cfg.shift_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      p2.valid <= 1'b0;
      p3.valid <= 1'b0;
      p4.valid <= 1'b0;
    end else begin
      p2.valid <= step_in.valid;
      p3.valid <= p2.valid;
      p4.valid <= p3.valid;
    end
    p2.row_last <= step_in.row_last;
    p2.run_last <= step_in.run_last;
    p3.row_last <= p2.row_last;
    p3.run_last <= p2.run_last;
    p4.row_last <= p3.row_last;
    p4.run_last <= p3.run_last;
    grp_q   <= grp_sum;
    total_q <= total;
  end

  assign res_valid    = p4.valid;
  assign res.pixel    = shifted[PIX_W-1:0];
  assign res.row_last = p4.row_last;
  assign res.run_last = p4.run_last;

endmodule

`default_nettype wire

>>> rtl/rlff_out_fifo.sv
// ----------------------------------------------------------------------------
// rlff_out_fifo
// Small result queue between the filter pipeline and the output stream.
// ----------------------------------------------------------------------------
`default_nettype none

module rlff_out_fifo
  import rlff_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire res_t                 push_data,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,
  output logic                      m_tlast,
  output logic                      m_tuser
);

  res_t                  mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [FIFO_CNT_W-1:0] count;
  logic                  pop;
  res_t                  head;

  assign head     = mem[rd_ptr];
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;
  assign m_tdata  = M_TDATA_W'(head.pixel);
  assign m_tlast  = head.row_last;
  assign m_tuser  = head.run_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_PTR_W'(1);
      end
      count <= count + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |-> (count < FIFO_CNT_W'(FIFO_DEPTH)))
    else $error("result queue overflow");

endmodule

`default_nettype wire

>>> rtl/row_lut_fir_filter_top.sv
// ----------------------------------------------------------------------------
// row_lut_fir_filter_top
// Horizontal FIR over a pixel stream with per-tap product lookup tables.
// ----------------------------------------------------------------------------
// Use:
//   The slave stream carries two kinds of transaction, told apart by
//   s_tuser: a pixel (s_tlast marks the last pixel of a row) or a table
//   load that writes one product word for one tap and pixel level. Loads
//   give no result. Each pixel yields at most one filtered pixel; the last
//   pixel of a row also replays itself radius times, one per cycle while
//   queue space allows, to flush the remaining outputs of the row, and
//   s_tready stays low during that replay. The master stream carries
//   filtered pixels; m_tlast marks the last pixel of a row, m_tuser the
//   last result of one transaction. One transaction is taken per cycle
//   otherwise, while queue space allows. m_tvalid for a result rises once
//   its pixel has passed the window register, the table read, two adder
//   tree stages and the output queue. Up to eight results may be in
//   flight or waiting; when the receiver stalls and that many are held,
//   s_tready drops until results drain. Reset restores the default
//   configuration and starts a new row; tables hold nothing defined until
//   loaded. The user must write configuration only while the block is
//   idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module row_lut_fir_filter_top
  import rlff_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // s_tdata from bit 0: pixel[7:0], table_tap[4:0], table_level[7:0],
  // table_word[23:0], zero fill
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  input  wire logic                  s_tlast,   // row_end
  input  wire logic                  s_tuser,   // req_type
  // Output stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [M_TDATA_W-1:0]       m_tdata,   // filtered_pixel[7:0]
  output logic                       m_tlast,   // row_last
  output logic                       m_tuser    // run_last
);

  cfg_t                  cfg;
  logic [FIFO_CNT_W-1:0] used;
  logic                  credit_ok;
  logic                  produce;
  logic                  out_acc;
  window_t               window;
  step_t                 step;
  tbl_wr_t               tbl_wr;
  logic                  res_valid;
  res_t                  res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tap_count    <= TAP_COUNT_RESET;
      cfg.round_offset <= '0;
      cfg.shift_amount <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_COUNT:    cfg.tap_count    <= cfg_data[TAP_COUNT_W-1:0];
        CFG_ROUND_OFFSET: cfg.round_offset <= cfg_data[OFF_W-1:0];
        CFG_SHIFT_AMOUNT: cfg.shift_amount <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // Every result is counted from the cycle it is started until the
  // receiver takes it, so the queue can never overflow.
  assign out_acc   = m_tvalid && m_tready;
  assign credit_ok = (used < FIFO_CNT_W'(FIFO_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else begin
      used <= used + FIFO_CNT_W'(produce) - FIFO_CNT_W'(out_acc);
    end
  end

  rlff_window_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .s_tuser   (s_tuser),
    .tap_count (cfg.tap_count),
    .credit_ok (credit_ok),
    .window    (window),
    .step_out  (step),
    .produce   (produce),
    .tbl_wr    (tbl_wr)
  );

  rlff_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .window    (window),
    .step_in   (step),
    .tbl_wr    (tbl_wr),
    .res_valid (res_valid),
    .res       (res)
  );

  rlff_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  a_used_bounded: assert property (@(posedge clk) disable iff (rst)
    used <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("outstanding result count beyond queue depth");

  a_valid_has_credit: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (used != '0))
    else $error("result shown that was never counted");

endmodule

`default_nettype wire
